>>> hw/rtl/tkcl_pkg.sv
// Shared types, constants and the key grid decoder for the touch keypad code lock.
package tkcl_pkg;

  // Entry length, shortest entry that is not reported as short, buffer sizing.
  localparam int CODE_LEN = 6;
  localparam int MIN_LEN  = 5;
  localparam int CNT_W    = $clog2(CODE_LEN + 1);
  localparam int IDX_W    = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;
  localparam int CODE_W   = 24;
  localparam int DIGIT_W  = 4;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] ADDR_STORED_CODE = 3'd0;

  // Touch event operations.
  localparam logic [1:0] OP_SET_X   = 2'd0;
  localparam logic [1:0] OP_SET_Y   = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  // Key codes.
  localparam logic [3:0] KEY_MAX_DIGIT = 4'd9;
  localparam logic [3:0] KEY_DEL       = 4'd10;
  localparam logic [3:0] KEY_ENT       = 4'd11;
  localparam logic [3:0] KEY_NONE      = 4'd12;

  // Event status codes.
  localparam logic [2:0] ST_NONE    = 3'd0;
  localparam logic [2:0] ST_STORED  = 3'd1;
  localparam logic [2:0] ST_REMOVED = 3'd2;
  localparam logic [2:0] ST_SHORT   = 3'd3;
  localparam logic [2:0] ST_WRONG   = 3'd4;
  localparam logic [2:0] ST_OK      = 3'd5;

  // Key grid boundaries in screen coordinates.
  localparam logic [9:0] COL_LEFT_LO  = 10'd221;
  localparam logic [9:0] COL_MID_LO   = 10'd328;
  localparam logic [9:0] COL_RIGHT_LO = 10'd450;
  localparam logic [9:0] COL_RIGHT_HI = 10'd580;
  localparam logic [9:0] ROW0_LO      = 10'd110;
  localparam logic [9:0] ROW1_LO      = 10'd192;
  localparam logic [9:0] ROW2_LO      = 10'd271;
  localparam logic [9:0] ROW3_LO      = 10'd336;
  localparam logic [9:0] ROW3_HI      = 10'd420;

  // One touch event request.
  typedef struct packed {
    logic [1:0] op;
    logic [9:0] coord;
  } in_req_t;

  // One result per touch event.
  typedef struct packed {
    logic [2:0] status;
    logic [2:0] digit_count;
    logic [3:0] key;
  } out_rsp_t;

  // Map a latched touch point onto the 3x4 keypad; outside the grid is no key.
  function automatic logic [3:0] decode_key(input logic [9:0] x, input logic [9:0] y);
    logic       col_ok;
    logic       row_ok;
    logic [1:0] col;
    logic [1:0] row;
    logic [3:0] k;
    col_ok = 1'b1;
    row_ok = 1'b1;
    col    = 2'd0;
    row    = 2'd0;
    if (x > COL_LEFT_LO && x < COL_MID_LO) begin
      col = 2'd0;
    end else if (x >= COL_MID_LO && x < COL_RIGHT_LO) begin
      col = 2'd1;
    end else if (x >= COL_RIGHT_LO && x < COL_RIGHT_HI) begin
      col = 2'd2;
    end else begin
      col_ok = 1'b0;
    end
    if (y > ROW0_LO && y < ROW1_LO) begin
      row = 2'd0;
    end else if (y >= ROW1_LO && y < ROW2_LO) begin
      row = 2'd1;
    end else if (y >= ROW2_LO && y < ROW3_LO) begin
      row = 2'd2;
    end else if (y >= ROW3_LO && y < ROW3_HI) begin
      row = 2'd3;
    end else begin
      row_ok = 1'b0;
    end
    case ({row, col})
      4'b0000: k = 4'd1;
      4'b0001: k = 4'd2;
      4'b0010: k = 4'd3;
      4'b0100: k = 4'd4;
      4'b0101: k = 4'd5;
      4'b0110: k = 4'd6;
      4'b1000: k = 4'd7;
      4'b1001: k = 4'd8;
      4'b1010: k = 4'd9;
      4'b1100: k = KEY_DEL;
      4'b1101: k = 4'd0;
      4'b1110: k = KEY_ENT;
      default: k = KEY_NONE;
    endcase
    if (!col_ok || !row_ok) begin
      k = KEY_NONE;
    end
    return k;
  endfunction

endpackage

>>> hw/rtl/touch_keypad_code_lock.sv
// Touch keypad code lock: key decode, digit buffer and code check in one registered pass.
// The lock takes one touch event per clock cycle unless stalled and returns one result per event.
// An event is held in an input register, decoded and applied to the latches and the
// digit buffer in a single pass of shallow logic, and its result lands in the output
// register once the output register can take it. The input side keeps accepting while a
// result waits, and stalls only when the input register is full and the output register
// is full and stalled. The code must be written through the APB port at byte address 0
// only while the lock is idle; the block itself does not enforce this.
module touch_keypad_code_lock
  import tkcl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // Touch event channel
  input  logic               in_valid,
  output logic               in_stall,
  input  in_req_t            in_data,
  // Result channel
  output logic               out_valid,
  input  logic               out_stall,
  output out_rsp_t           out_data,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [CODE_W-1:0]  code_r;
  logic               s1_vld_r;
  in_req_t            s1_req_r;
  logic               out_vld_r;
  out_rsp_t           out_rsp_r;
  logic [9:0]         x_r;
  logic [9:0]         y_r;
  logic [9:0]         x_nxt;
  logic [9:0]         y_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;
  logic [DIGIT_W-1:0] buf_r [CODE_LEN];

  logic               out_adv;
  logic               s1_fire;
  logic               in_acc;
  logic [3:0]         key;
  logic               is_digit;
  logic               buf_we;
  logic [CNT_W-1:0]   cnt_inc;
  logic               match;
  logic [2:0]         status;
  out_rsp_t           rsp;

  // Configuration register: written on the access phase, read back at any time.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r <= '0;
    end else if (psel && penable && pwrite && paddr == ADDR_STORED_CODE) begin
      code_r <= pwdata[CODE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_STORED_CODE) begin
      prdata = {{(PDATA_W-CODE_W){1'b0}}, code_r};
    end
  end

  // Handshake: the output register frees when empty or taken, the input register
  // moves forward whenever the output register can take its result.
  assign out_adv  = !out_vld_r || !out_stall;
  assign s1_fire  = s1_vld_r && out_adv;
  assign in_stall = s1_vld_r && !out_adv;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_acc) begin
      s1_vld_r <= 1'b1;
    end else if (s1_fire) begin
      s1_vld_r <= 1'b0;
    end
    if (in_acc) begin
      s1_req_r <= in_data;
    end
  end

  // Key decode of the latched point on a release.
  always_comb begin
    key = KEY_NONE;
    if (s1_req_r.op == OP_RELEASE) begin
      key = decode_key(x_r, y_r);
    end
  end

  assign is_digit = (key <= KEY_MAX_DIGIT);
  assign cnt_inc  = cnt_r + CNT_W'(1);

  // Compare the entry with the new digit placed at the current count position.
  // Digit i sits in the code from the top nibble down.
  always_comb begin
    logic [DIGIT_W-1:0] d;
    match = 1'b1;
    for (int i = 0; i < CODE_LEN; i++) begin
      d = (cnt_r == CNT_W'(i)) ? key : buf_r[i];
      if (d != code_r[CODE_W-DIGIT_W-DIGIT_W*i +: DIGIT_W]) begin
        match = 1'b0;
      end
    end
  end

  // Event processing: latches, digit buffer, count and status.
  always_comb begin
    x_nxt   = x_r;
    y_nxt   = y_r;
    cnt_nxt = cnt_r;
    buf_we  = 1'b0;
    status  = ST_NONE;
    case (s1_req_r.op)
      OP_SET_X: begin
        x_nxt = s1_req_r.coord;
      end
      OP_SET_Y: begin
        y_nxt = s1_req_r.coord;
      end
      OP_RELEASE: begin
        if (is_digit) begin
          buf_we = 1'b1;
          if (cnt_inc >= CNT_W'(CODE_LEN)) begin
            // Entry is full: check it at once.
            cnt_nxt = '0;
            if (cnt_inc < CNT_W'(MIN_LEN)) begin
              status = ST_SHORT;
            end else if (cnt_inc != CNT_W'(CODE_LEN)) begin
              status = ST_WRONG;
            end else begin
              status = match ? ST_OK : ST_WRONG;
            end
          end else begin
            cnt_nxt = cnt_inc;
            status  = ST_STORED;
          end
        end else if (key == KEY_DEL) begin
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - CNT_W'(1);
            status  = ST_REMOVED;
          end
        end else if (key == KEY_ENT) begin
          // Enter always clears and reports a short or wrong entry; a full entry never waits here.
          cnt_nxt = '0;
          if (cnt_r < CNT_W'(MIN_LEN)) begin
            status = ST_SHORT;
          end else begin
            status = ST_WRONG;
          end
        end
      end
      default: begin
        status = ST_NONE;
      end
    endcase
  end

  always_comb begin
    rsp.status      = status;
    rsp.digit_count = cnt_nxt;
    rsp.key         = key;
  end

  // State registers, updated once per event as it leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r   <= '0;
      y_r   <= '0;
      cnt_r <= '0;
    end else if (s1_fire) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Digit buffer: no reset, only entries below the count are ever compared.
  always_ff @(posedge clk) begin
    if (s1_fire && buf_we && cnt_r < CNT_W'(CODE_LEN)) begin
      buf_r[cnt_r[IDX_W-1:0]] <= key;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_adv) begin
      out_vld_r <= s1_vld_r;
    end
    if (s1_fire) begin
      out_rsp_r <= rsp;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_rsp_r;

endmodule
